// ----- hdl/burr_pkg.sv -----
// Shared types and constants for the bounded undo/redo history ring.
package burr_pkg;

	localparam int ACTION_W = 2;
	localparam int DATA_W   = 32;

	typedef logic [ACTION_W-1:0] action_t;
	typedef logic [DATA_W-1:0]   data_t;

	localparam action_t ACT_PUSH  = 2'd0;
	localparam action_t ACT_UNDO  = 2'd1;
	localparam action_t ACT_REDO  = 2'd2;
	localparam action_t ACT_CLEAR = 2'd3;

endpackage

// ----- hdl/burr_cmd_if.sv -----
// Request channel carrying history commands into the ring.
interface burr_cmd_if import burr_pkg::*;;
	logic    valid;
	logic    ready;
	action_t action;
	data_t   entry_data;

	modport source (output valid, output action, output entry_data, input ready);
	modport sink   (input valid, input action, input entry_data, output ready);
endinterface

// ----- hdl/burr_rsp_if.sv -----
// Result channel carrying the outcome of each history command.
interface burr_rsp_if import burr_pkg::*;;
	logic  valid;
	logic  ready;
	logic  found;
	data_t entry_out;
	logic  can_undo;
	logic  can_redo;

	modport source (output valid, output found, output entry_out, output can_undo,
		output can_redo, input ready);
	modport sink   (input valid, input found, input entry_out, input can_undo,
		input can_redo, output ready);
endinterface

// ----- hdl/burr_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
module burr_ram #(
	parameter int WIDTH  = 32,
	parameter int DEPTH  = 64,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- hdl/bounded_undo_redo_ring.sv -----
// Latency: a result appears in the cycle after its request is accepted.
// Throughput: one request per cycle while results drain; the pointers update in a single
// pass and the entry store does at most one write or one registered read per request.
// The request side stalls only while a finished result waits on the result side.
// Reset clears head, live count, cursor and the result valid; the entry store is
// not cleared, since only slots written since the last clear are ever read.
module bounded_undo_redo_ring import burr_pkg::*; #(
	parameter int DEPTH      = 64,
	parameter int ENTRY_BITS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	burr_cmd_if.sink   cmd,
	burr_rsp_if.source rsp
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int SUM_W = PTR_W + 1;
	localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(DEPTH);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

	logic [PTR_W-1:0] head_q, head_d;
	logic [CNT_W-1:0] live_q, live_d;
	logic [CNT_W-1:0] cursor_q, cursor_d;

	logic             valid_s1;
	logic             found_s1;
	logic             can_undo_s1;
	logic             can_redo_s1;

	logic             accept;
	logic             found_d;
	logic             wr_en;
	logic             rd_en;
	logic [PTR_W-1:0] wr_addr;
	logic [PTR_W-1:0] rd_addr;
	logic [ENTRY_BITS-1:0] wr_data;
	logic [ENTRY_BITS-1:0] rd_data;

	// Head plus an offset below DEPTH stays under twice DEPTH, so one subtract wraps it.
	function automatic logic [PTR_W-1:0] wrap(input logic [SUM_W-1:0] s);
		if (s >= DEPTH_S) begin
			return PTR_W'(s - DEPTH_S);
		end
		return PTR_W'(s);
	endfunction

	assign accept    = cmd.valid && cmd.ready;
	assign cmd.ready = !valid_s1 || rsp.ready;
	assign wr_data   = ENTRY_BITS'(cmd.entry_data);

	always_comb begin
		head_d   = head_q;
		live_d   = live_q;
		cursor_d = cursor_q;
		found_d  = 1'b0;
		wr_en    = 1'b0;
		rd_en    = 1'b0;
		wr_addr  = wrap({1'b0, head_q} + SUM_W'(cursor_q));
		rd_addr  = wrap({1'b0, head_q} + SUM_W'(cursor_q));
		unique case (cmd.action)
			ACT_PUSH: begin
				wr_en = 1'b1;
				// A push on a full ring overwrites the oldest slot and moves head past it.
				if (cursor_q == DEPTH_C) begin
					head_d   = wrap({1'b0, head_q} + SUM_W'(1));
					wr_addr  = head_q;
					live_d   = DEPTH_C;
					cursor_d = DEPTH_C;
				end else begin
					live_d   = cursor_q + CNT_W'(1);
					cursor_d = cursor_q + CNT_W'(1);
				end
			end
			ACT_UNDO: begin
				if (cursor_q != '0) begin
					cursor_d = cursor_q - CNT_W'(1);
					rd_addr  = wrap({1'b0, head_q} + SUM_W'(cursor_q - CNT_W'(1)));
					rd_en    = 1'b1;
					found_d  = 1'b1;
				end
			end
			ACT_REDO: begin
				if (cursor_q < live_q) begin
					cursor_d = cursor_q + CNT_W'(1);
					rd_en    = 1'b1;
					found_d  = 1'b1;
				end
			end
			ACT_CLEAR: begin
				head_d   = '0;
				live_d   = '0;
				cursor_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			live_q   <= '0;
			cursor_q <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				head_q   <= head_d;
				live_q   <= live_d;
				cursor_q <= cursor_d;
				valid_s1 <= 1'b1;
			end else if (rsp.ready) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			found_s1    <= found_d;
			can_undo_s1 <= (cursor_d != '0);
			can_redo_s1 <= (cursor_d < live_d);
		end
	end

	// The store is read only on an accepted request, so its read data holds during a stall.
	burr_ram #(
		.WIDTH (ENTRY_BITS),
		.DEPTH (DEPTH),
		.ADDR_W(PTR_W)
	) u_store (
		.clk    (clk),
		.wr_en  (accept && wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (accept && rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign rsp.valid     = valid_s1;
	assign rsp.found     = found_s1;
	assign rsp.entry_out = found_s1 ? DATA_W'(rd_data) : '0;
	assign rsp.can_undo  = can_undo_s1;
	assign rsp.can_redo  = can_redo_s1;

endmodule

// ----- hdl/burr_chk.sv -----
// Port-level checks for the undo/redo ring, bound to the top level.
module burr_chk import burr_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    cmd_valid,
	input logic    cmd_ready,
	input action_t cmd_action,
	input logic    rsp_valid,
	input logic    rsp_ready,
	input logic    found,
	input data_t   entry_out,
	input logic    can_undo,
	input logic    can_redo
);

	// Every accepted request produces a result in the next cycle.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> rsp_valid)
		else $error("no result after an accepted request");

	// A stalled result blocks new requests, since there is only one result slot.
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |-> !cmd_ready)
		else $error("request taken while a result was stalled");

	// A stalled result keeps its payload.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(found) && $stable(entry_out)
			&& $stable(can_undo) && $stable(can_redo))
		else $error("stalled result changed");

	// An entry is returned only together with the found flag.
	a_entry_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !found |-> entry_out == '0)
		else $error("entry returned without found");

	// A clear leaves nothing to undo or redo.
	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && cmd_action == ACT_CLEAR |=>
			rsp_valid && !found && !can_undo && !can_redo)
		else $error("history not empty after clear");

endmodule

bind bounded_undo_redo_ring burr_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd.valid),
	.cmd_ready (cmd.ready),
	.cmd_action(cmd.action),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.found     (rsp.found),
	.entry_out (rsp.entry_out),
	.can_undo  (rsp.can_undo),
	.can_redo  (rsp.can_redo)
);

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the bounded undo/redo history ring.
module testbench;
	import burr_pkg::*;

	localparam int HIST_DEPTH  = 64;
	localparam int QUIET_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 10;

	typedef struct packed {
		logic  found;
		data_t entry;
		logic  can_undo;
		logic  can_redo;
	} history_result_t;

	typedef enum int {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_CHOKED} rx_mode_t;

	logic clk;
	logic arst_n;

	burr_cmd_if cmd ();
	burr_rsp_if rsp ();

	bounded_undo_redo_ring #(
		.DEPTH     (HIST_DEPTH),
		.ENTRY_BITS(DATA_W)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.rsp   (rsp)
	);

	// Predicted history state, updated as each request is accepted.
	data_t      hist_store [HIST_DEPTH];
	logic [5:0] hist_head;
	logic [6:0] hist_live;
	logic [6:0] hist_cursor;

	history_result_t pending_results [$];

	int failures;
	int results_seen;
	int requests_sent;
	int pushes, wrap_pushes, clears, undo_hits, redo_hits, edge_misses;
	int burst_left;
	bit steady_send;
	int quiet_cycles;
	rx_mode_t stall_mode;
	int stall_left;
	int stall_phase;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic history_result_t predict_history(action_t act, data_t data);
		history_result_t res;
		logic [5:0] slot;
		res = '0;
		case (act)
			ACT_PUSH: begin
				// The redo tail goes first; a full ring then loses its oldest entry.
				hist_live = hist_cursor;
				if (hist_live >= HIST_DEPTH) begin
					hist_head = hist_head + 6'd1;
					hist_live = 7'(HIST_DEPTH - 1);
					wrap_pushes++;
				end
				slot = hist_head + hist_live[5:0];
				hist_store[slot] = data;
				hist_live = hist_live + 7'd1;
				hist_cursor = hist_live;
				pushes++;
			end
			ACT_UNDO: begin
				if (hist_cursor != 7'd0) begin
					hist_cursor = hist_cursor - 7'd1;
					slot = hist_head + hist_cursor[5:0];
					res.found = 1'b1;
					res.entry = hist_store[slot];
					undo_hits++;
				end else begin
					edge_misses++;
				end
			end
			ACT_REDO: begin
				if (hist_cursor < hist_live) begin
					slot = hist_head + hist_cursor[5:0];
					res.found = 1'b1;
					res.entry = hist_store[slot];
					hist_cursor = hist_cursor + 7'd1;
					redo_hits++;
				end else begin
					edge_misses++;
				end
			end
			ACT_CLEAR: begin
				hist_head = '0;
				hist_live = '0;
				hist_cursor = '0;
				clears++;
			end
		endcase
		res.can_undo = (hist_cursor != 7'd0);
		res.can_redo = (hist_cursor < hist_live);
		return res;
	endfunction

	function automatic void report_failure(string msg);
		failures++;
		if (failures <= 10)
			$display("ERROR at %0t: %s", $realtime, msg);
	endfunction

	// Sends one request, opening a random gap between bursts unless sending steadily.
	task automatic send_command(action_t act, data_t data);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			if (!steady_send && $urandom_range(0, 2) != 0) begin
				gap = $urandom_range(1, 6);
				@(negedge clk);
				cmd.valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		cmd.valid      <= 1'b1;
		cmd.action     <= act;
		cmd.entry_data <= data;
		do @(posedge clk); while (!cmd.ready);
		pending_results.insert(pending_results.size(), predict_history(act, data));
		requests_sent++;
	endtask

	task automatic test_empty_history();
		send_command(ACT_UNDO, 32'hDEAD_BEEF);
		send_command(ACT_REDO, 32'h1234_5678);
		send_command(ACT_CLEAR, 32'hFFFF_FFFF);
	endtask

	task automatic test_push_undo_redo();
		send_command(ACT_PUSH, 32'h0000_0000);
		send_command(ACT_PUSH, 32'hFFFF_FFFF);
		send_command(ACT_PUSH, 32'h5A5A_5A5A);
		repeat (4) send_command(ACT_UNDO, 32'h0);
		repeat (4) send_command(ACT_REDO, 32'h0);
	endtask

	task automatic test_redo_tail_discard();
		send_command(ACT_UNDO, 32'h0);
		send_command(ACT_UNDO, 32'h0);
		send_command(ACT_PUSH, 32'hA5A5_A5A5);
		send_command(ACT_REDO, 32'h0);
		send_command(ACT_UNDO, 32'h0);
		send_command(ACT_UNDO, 32'h0);
		send_command(ACT_CLEAR, 32'h0);
		send_command(ACT_REDO, 32'h0);
		send_command(ACT_UNDO, 32'h0);
	endtask

	// Overfills the ring, then walks the cursor past both ends.
	task automatic test_ring_wrap();
		steady_send = 1'b1;
		send_command(ACT_CLEAR, $urandom());
		repeat (HIST_DEPTH + 6) send_command(ACT_PUSH, $urandom());
		steady_send = 1'b0;
		repeat (HIST_DEPTH + 2) send_command(ACT_UNDO, $urandom());
		repeat (HIST_DEPTH + 2) send_command(ACT_REDO, $urandom());
	endtask

	task automatic test_random_history(int budget);
		int sent;
		int run;
		int kind;
		sent = 0;
		while (sent < budget) begin
			steady_send = ($urandom_range(0, 3) == 0);
			kind = $urandom_range(0, 9);
			case (kind)
				0, 1, 2, 3: begin
					run = $urandom_range(1, 24);
					repeat (run) send_command(ACT_PUSH, $urandom());
				end
				4, 5: begin
					run = $urandom_range(1, int'(hist_cursor) + 2);
					repeat (run) send_command(ACT_UNDO, $urandom());
				end
				6, 7: begin
					run = $urandom_range(1, int'(hist_live - hist_cursor) + 2);
					repeat (run) send_command(ACT_REDO, $urandom());
				end
				8: begin
					run = 1;
					if ($urandom_range(0, 3) == 0)
						send_command(ACT_CLEAR, $urandom());
					else
						send_command(action_t'($urandom_range(0, 2)), $urandom());
				end
				default: begin
					run = 1;
					send_command(action_t'($urandom_range(0, 3)), $urandom());
				end
			endcase
			sent += run;
		end
	endtask

	// Result-side ready follows one behavior for a stretch before a new one is picked at random.
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = rx_mode_t'($urandom_range(0, 3));
			stall_left = $urandom_range(20, 60);
		end
		stall_left--;
		stall_phase++;
		case (stall_mode)
			RX_OPEN:     rsp.ready <= 1'b1;
			RX_RANDOM:   rsp.ready <= ($urandom_range(0, 3) != 0);
			RX_PERIODIC: rsp.ready <= (stall_phase % 3 != 0);
			RX_CHOKED:   rsp.ready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	always @(posedge clk) begin
		history_result_t got;
		history_result_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			results_seen++;
			got.found    = rsp.found;
			got.entry    = rsp.entry_out;
			got.can_undo = rsp.can_undo;
			got.can_redo = rsp.can_redo;
			if (pending_results.size() == 0) begin
				report_failure($sformatf("unexpected result found=%b entry=%h undo=%b redo=%b",
					got.found, got.entry, got.can_undo, got.can_redo));
			end else begin
				want = pending_results.pop_front();
				if (got.found !== want.found || got.entry !== want.entry ||
						got.can_undo !== want.can_undo || got.can_redo !== want.can_redo) begin
					report_failure($sformatf({"result %0d: expected found=%b entry=%h undo=%b ",
						"redo=%b, got found=%b entry=%h undo=%b redo=%b"}, results_seen,
						want.found, want.entry, want.can_undo, want.can_redo,
						got.found, got.entry, got.can_undo, got.can_redo));
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((cmd.valid && cmd.ready) || (rsp.valid && rsp.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Watchdog: nothing accepted for %0d cycles, %0d results outstanding",
				quiet_cycles, pending_results.size());
			$display("bounded_undo_redo_ring verification failed");
			$finish;
		end
	end

	initial begin
		arst_n         = 1'b0;
		cmd.valid      = 1'b0;
		cmd.action     = ACT_PUSH;
		cmd.entry_data = '0;
		rsp.ready      = 1'b0;
		hist_head      = '0;
		hist_live      = '0;
		hist_cursor    = '0;
		foreach (hist_store[i]) hist_store[i] = '0;
		failures = 0;
		results_seen = 0;
		requests_sent = 0;
		pushes = 0;
		wrap_pushes = 0;
		clears = 0;
		undo_hits = 0;
		redo_hits = 0;
		edge_misses = 0;
		burst_left = 0;
		steady_send = 1'b0;
		quiet_cycles = 0;
		stall_mode = RX_OPEN;
		stall_left = 0;
		stall_phase = 0;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_history();
		test_push_undo_redo();
		test_redo_tail_discard();
		test_ring_wrap();
		test_random_history(300);

		@(negedge clk);
		cmd.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Covered %0d requests: %0d pushes (%0d onto a full ring) and %0d clears.",
			requests_sent, pushes, wrap_pushes, clears);
		$display("Undo returned %0d entries, redo %0d; %0d undo or redo requests hit an edge.",
			undo_hits, redo_hits, edge_misses);
		if (failures == 0 && pending_results.size() == 0) begin
			$display("bounded_undo_redo_ring verification clean");
		end else begin
			$display("%0d failures counted", failures);
			$display("bounded_undo_redo_ring verification failed");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/burr_pkg.sv
hdl/burr_cmd_if.sv
hdl/burr_rsp_if.sv
hdl/burr_ram.sv
hdl/bounded_undo_redo_ring.sv
hdl/burr_chk.sv
tb/testbench.sv
